/* rtl/tun_pkg.sv */
package tun_pkg;
  localparam int CW   = 24;   // coordinate
  localparam int EW   = CW + 1;  // edge
  localparam int PW   = 2 * EW;  // edge product
  localparam int MW   = PW - 1;  // cross magnitude
  localparam int HW   = MW / 2;  // upper half of magnitude
  localparam int LOW  = MW - HW; // lower half
  localparam int QW   = 2 * MW;  // one square
  localparam int SW   = QW + 2;  // sum of squares
  localparam int LW   = SW / 2;  // length
  localparam int RW   = LW + 1;  // root remainder
  localparam int OW   = 16;      // normal component
  localparam int FW   = OW - 1;  // fraction bits
  localparam int MLW  = 40;
  localparam int DW   = LW + 1;  // divider remainder
  localparam logic [OW-1:0] UMAX = {1'b0, {FW{1'b1}}};

  typedef struct packed {
    logic [2:0]         neg;
    logic [2:0][MW-1:0] mag;
  } vec_t;
endpackage

/* rtl/triangle_unit_normal.sv */
// channel  dir  beat payload
// s_axis   in   tdata[215:0] = a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z (24b each)
// m_axis   out  tdata[47:0]  = unit_x,unit_y,unit_z; tuser = degenerate
// cfg      in   cfg_data[39:0] = min_length
// One triangle per cycle while the output beat is not waiting.
// Length takes one root bit per stage (50 stages), each quotient one bit per
// stage (15 stages) after edge, cross, square and sum stages.
// rst clears valid bits and min_length; payload regs are not reset.
// The whole pipe holds when the output beat waits; s_tready drops with it.
module triangle_unit_normal import tun_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [9*CW-1:0] s_tdata,  // a_x a_y a_z b_x b_y b_z c_x c_y c_z
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [3*OW-1:0] m_tdata,  // unit_x unit_y unit_z
  output logic           m_tuser,   // degenerate
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [MLW-1:0] cfg_data
);
  localparam int NS = 7 + LW + 1 + FW + 1;

  logic [MLW-1:0] min_length;
  logic adv;
  logic [NS-1:0] vld;

  assign adv       = !vld[NS-1] || m_tready;
  assign s_tready  = adv;
  assign m_tvalid  = vld[NS-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], s_tvalid};
    end
  end

  // edges
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= $signed({s_tdata[(3+i)*CW+CW-1], s_tdata[(3+i)*CW +: CW]})
               - $signed({s_tdata[i*CW+CW-1], s_tdata[i*CW +: CW]});
        e2[i] <= $signed({s_tdata[(6+i)*CW+CW-1], s_tdata[(6+i)*CW +: CW]})
               - $signed({s_tdata[i*CW+CW-1], s_tdata[i*CW +: CW]});
      end
    end
  end

  // cross product terms
  logic signed [PW-1:0] p [6];
  always_ff @(posedge clk) begin
    if (adv) begin
      p[0] <= e1[1] * e2[2];
      p[1] <= e1[2] * e2[1];
      p[2] <= e1[2] * e2[0];
      p[3] <= e1[0] * e2[2];
      p[4] <= e1[0] * e2[1];
      p[5] <= e1[1] * e2[0];
    end
  end

  logic signed [PW-1:0] n [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) n[i] <= p[2*i] - p[2*i+1];
    end
  end

  vec_t v4;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        v4.neg[i] <= n[i][PW-1];
        v4.mag[i] <= n[i][PW-1] ? MW'(-n[i]) : MW'(n[i]);
      end
    end
  end

  // squares from half-width partial products
  vec_t v5, v6, v7;
  logic [2*HW-1:0]     hh [3];
  logic [HW+LOW-1:0]   hl [3];
  logic [2*LOW-1:0]    ll [3];
  logic [QW-1:0]       sq [3];
  logic [SW-1:0]       ssum;
  always_ff @(posedge clk) begin
    if (adv) begin
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      for (int i = 0; i < 3; i++) begin
        hh[i] <= v4.mag[i][MW-1:LOW] * v4.mag[i][MW-1:LOW];
        hl[i] <= v4.mag[i][MW-1:LOW] * v4.mag[i][LOW-1:0];
        ll[i] <= v4.mag[i][LOW-1:0] * v4.mag[i][LOW-1:0];
        sq[i] <= (QW'(hh[i]) << (2*LOW)) + (QW'(hl[i]) << (LOW+1)) + QW'(ll[i]);
      end
      ssum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
    end
  end

  // integer square root, one root bit per stage
  vec_t           rv   [LW+1];
  logic [RW-1:0]  rrem [LW+1];
  logic [LW-1:0]  root [LW+1];
  logic [SW-1:0]  rs   [LW+1];
  assign rv[0]   = v7;
  assign rrem[0] = '0;
  assign root[0] = '0;
  assign rs[0]   = ssum;

  for (genvar k = 0; k < LW; k++) begin : g_sqrt
    logic [RW+1:0] trial;
    logic [RW+1:0] tsub;
    assign trial = {rrem[k], rs[k][SW-1:SW-2]};
    assign tsub  = (RW+2)'({root[k], 2'b01});
    always_ff @(posedge clk) begin
      if (adv) begin
        rv[k+1] <= rv[k];
        rs[k+1] <= rs[k] << 2;
        if (trial >= tsub) begin
          rrem[k+1] <= RW'(trial - tsub);
          root[k+1] <= {root[k][LW-2:0], 1'b1};
        end else begin
          rrem[k+1] <= RW'(trial);
          root[k+1] <= {root[k][LW-2:0], 1'b0};
        end
      end
    end
  end

  // division, one quotient bit per stage
  logic [2:0]         dneg [FW+1];
  logic [2:0]         dsat [FW+1];
  logic               ddeg [FW+1];
  logic [LW-1:0]      dlen [FW+1];
  logic [2:0][DW-1:0] drem [FW+1];
  logic [2:0][FW-1:0] dq   [FW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dneg[0] <= rv[LW].neg;
      ddeg[0] <= root[LW] <= LW'(min_length);
      dlen[0] <= root[LW];
      for (int i = 0; i < 3; i++) begin
        dsat[0][i] <= LW'(rv[LW].mag[i]) >= root[LW];
        drem[0][i] <= DW'(rv[LW].mag[i]);
        dq[0][i]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < FW; j++) begin : g_div
    logic [2:0][DW:0] dbl;
    for (genvar i = 0; i < 3; i++) begin : g_c
      assign dbl[i] = {drem[j][i], 1'b0};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dneg[j+1] <= dneg[j];
        dsat[j+1] <= dsat[j];
        ddeg[j+1] <= ddeg[j];
        dlen[j+1] <= dlen[j];
        for (int i = 0; i < 3; i++) begin
          if (dbl[i] >= (DW+1)'(dlen[j])) begin
            drem[j+1][i] <= DW'(dbl[i] - (DW+1)'(dlen[j]));
            dq[j+1][i]   <= {dq[j][i][FW-2:0], 1'b1};
          end else begin
            drem[j+1][i] <= DW'(dbl[i]);
            dq[j+1][i]   <= {dq[j][i][FW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // round half away from zero, saturate, sign, fallback
  logic [2:0][OW-1:0] qr;
  logic [2:0][OW-1:0] mg;
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign qr[i] = OW'(dq[FW][i]) +
                   OW'(drem[FW][i] >= DW'(dlen[FW]) - drem[FW][i]);
    assign mg[i] = (dsat[FW][i] || qr[i] > UMAX) ? UMAX : qr[i];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= ddeg[FW];
      for (int i = 0; i < 3; i++) begin
        if (ddeg[FW]) m_tdata[i*OW +: OW] <= (i == 1) ? UMAX : '0;
        else          m_tdata[i*OW +: OW] <= dneg[FW][i] ? OW'(-mg[i]) : mg[i];
      end
    end
  end

  a_deg_val: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[OW +: OW] == UMAX && m_tdata[0 +: OW] == '0)
    else $error("degenerate beat without fallback normal");
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OW-1 -: OW] != {1'b1, {FW{1'b0}}}
              && m_tdata[2*OW-1 -: OW] != {1'b1, {FW{1'b0}}}
              && m_tdata[3*OW-1 -: OW] != {1'b1, {FW{1'b0}}})
    else $error("normal component at negative full scale");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output beat dropped while stalled");
endmodule
